// File: sv/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants and codes for the minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    // default geometry
    localparam int unsigned MTS_STACK_DEPTH = 1024;
    localparam int unsigned MTS_VALUE_WIDTH = 32;

    // operation codes carried on the input beat
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY_POP = 2'd1,
        STATUS_FULL_PUSH = 2'd2
    } status_t;

endpackage

// File: sv/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 34
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// LIFO stack of signed words that reports its minimum after every operation.
// ----------------------------------------------------------------------------
// A push, a push refused because the stack is full and a pop of an empty
// stack each load the result register directly; a pop of a non-empty stack
// first issues a memory read, then takes the registered top word in ST_POP.
// One beat is in flight at a time: s_tready is high when no pop is waiting on
// the memory and the result register is free or being drained in that cycle.
// Words below the running minimum are stored encoded (2*value - minimum, two
// bits wider than a value) so the previous minimum is restored on pop without
// a second store. Every input beat yields exactly one result beat.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
    parameter int unsigned STACK_DEPTH = mts_pkg::MTS_STACK_DEPTH,
    parameter int unsigned VALUE_WIDTH = mts_pkg::MTS_VALUE_WIDTH
) (
    input  logic aclk,
    input  logic aresetn,
    // input channel
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: push_value
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,
    // tuser: opcode
    input  logic                                   s_tuser,
    // result channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: popped_value, current_minimum, stack_empty, occupancy, status
    output logic [((2*VALUE_WIDTH+$clog2(STACK_DEPTH+1)+3+7)/8)*8-1:0] m_tdata
);

    import mts_pkg::*;

    localparam int unsigned W     = VALUE_WIDTH;
    localparam int unsigned EW    = VALUE_WIDTH + 2;
    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW    = $clog2(STACK_DEPTH);
    localparam int unsigned OUT_W = ((2*VALUE_WIDTH+$clog2(STACK_DEPTH+1)+3+7)/8)*8;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [W-1:0]     min_reg, min_next;
    logic                    m_valid_reg, m_valid_next;
    logic signed [W-1:0]     popped_reg, popped_next;
    logic signed [W-1:0]     min_out_reg, min_out_next;
    logic                    empty_reg, empty_next;
    logic [CNT_W-1:0]        occ_reg, occ_next;
    status_t                 status_reg, status_next;

    logic                    accept;
    logic signed [W-1:0]     push_value;
    logic signed [EW-1:0]    push_ext, min_ext, encoded, restored;
    logic signed [EW-1:0]    rd_word;
    logic                    wr_en, rd_en;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic [EW-1:0]           wr_data;
    logic [EW-1:0]           mts_rd_data;
    logic [CNT_W-1:0]        count_dec;
    logic                    full;

    assign s_tready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign push_value = s_tdata[W-1:0];

    // widened operands for the encoded arithmetic
    assign push_ext  = {{2{push_value[W-1]}}, push_value};
    assign min_ext   = {{2{min_reg[W-1]}}, min_reg};
    assign encoded   = (push_ext <<< 1) - min_ext;
    assign rd_word   = mts_rd_data;
    assign restored  = (min_ext <<< 1) - rd_word;
    assign full      = (count_reg == CNT_W'(STACK_DEPTH));
    assign count_dec = count_reg - CNT_W'(1);

    // memory addressing
    assign wr_addr = count_reg[AW-1:0];
    assign rd_addr = count_dec[AW-1:0];
    assign rd_en   = accept && (s_tuser == OP_POP) && (count_reg != '0);

    always_comb begin
        wr_en = 1'b0;
        wr_data = EW'(push_value);
        if (accept && (s_tuser == OP_PUSH) && !full) begin
            wr_en = 1'b1;
            if ((count_reg != '0) && (push_value < min_reg)) begin
                wr_data = encoded;
            end else begin
                wr_data = push_ext;
            end
        end
    end

    mts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (mts_rd_data)
    );

    // next-state and result logic
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        min_next     = min_reg;
        m_valid_next = m_valid_reg && !m_tready;
        popped_next  = popped_reg;
        min_out_next = min_out_reg;
        empty_next   = empty_reg;
        occ_next     = occ_reg;
        status_next  = status_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_PUSH) begin
                        popped_next = '0;
                        if (full) begin
                            status_next  = STATUS_FULL_PUSH;
                            min_out_next = min_reg;
                            empty_next   = 1'b0;
                            occ_next     = count_reg;
                        end else begin
                            status_next = STATUS_OK;
                            count_next  = count_reg + CNT_W'(1);
                            if ((count_reg == '0) || (push_value < min_reg)) begin
                                min_next     = push_value;
                                min_out_next = push_value;
                            end else begin
                                min_out_next = min_reg;
                            end
                            empty_next = 1'b0;
                            occ_next   = count_reg + CNT_W'(1);
                        end
                        m_valid_next = 1'b1;
                    end else if (count_reg == '0) begin
                        // pop of an empty stack
                        popped_next  = {W{1'b1}};
                        min_out_next = {W{1'b1}};
                        empty_next   = 1'b1;
                        occ_next     = '0;
                        status_next  = STATUS_EMPTY_POP;
                        m_valid_next = 1'b1;
                    end else begin
                        count_next = count_dec;
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                // top word has arrived from memory
                status_next = STATUS_OK;
                occ_next    = count_reg;
                empty_next  = (count_reg == '0);
                if (rd_word < min_ext) begin
                    popped_next = min_reg;
                    min_next    = restored[W-1:0];
                    min_out_next = (count_reg == '0) ? {W{1'b1}} : restored[W-1:0];
                end else begin
                    popped_next  = rd_word[W-1:0];
                    min_out_next = (count_reg == '0) ? {W{1'b1}} : min_reg;
                end
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            min_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            min_reg     <= min_next;
            m_valid_reg <= m_valid_next;
        end
        popped_reg  <= popped_next;
        min_out_reg <= min_out_next;
        empty_reg   <= empty_next;
        occ_reg     <= occ_next;
        status_reg  <= status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({status_reg, occ_reg, empty_reg, min_out_reg, popped_reg});

    // occupancy never passes the stack depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // the result register is free while a pop waits on the memory
    a_pop_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |-> !m_valid_reg)
        else $error("result register busy during pop read");

    // a pop read completes in the following cycle
    a_pop_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |=> (state_reg == ST_IDLE) && m_valid_reg)
        else $error("pop did not complete");

    // an accepted push that fits grows the stack by one
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == OP_PUSH) && !full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not grow the stack");

endmodule
